### rtl/dqse_pkg.sv
package dqse_pkg;

	// Sample and window geometry. The window mean is a shift, so the window
	// length must be a power of two.
	localparam int SAMPLE_W        = 16;
	localparam int WINDOW_LENGTH   = 256;
	localparam int UPDATE_INTERVAL = 64;

	localparam int WIN_AW = $clog2(WINDOW_LENGTH);
	localparam int CNT_W  = (UPDATE_INTERVAL > 1) ? $clog2(UPDATE_INTERVAL) : 1;

	// Magnitudes of a two's complement sample fit in SAMPLE_W unsigned bits.
	localparam int ABS_W  = SAMPLE_W;
	localparam int AMP_W  = ABS_W + 1;
	localparam int SUM_W  = ABS_W + WIN_AW;
	localparam int QUOT_W = ABS_W - 1;

	// floor(x / 5) = (x * 52429) >> 18, exact for x below 2**18.
	localparam int DIV5_MUL   = 52429;
	localparam int DIV5_MUL_W = 16;
	localparam int DIV5_SH    = 18;
	localparam int PROD_W     = ABS_W + 1 + DIV5_MUL_W;

	// Field widths of the ports.
	localparam int DIBIT_W = 2;
	localparam int MEAN_W  = 17;
	localparam int WEAK_W  = 16;
	localparam int SYNC_W  = 17;
	localparam int CFG_W   = 17;

	localparam logic [WEAK_W-1:0] WEAK_THR_RESET = WEAK_W'(2458);
	localparam logic [SYNC_W-1:0] SYNC_THR_RESET = SYNC_W'(5734);

	typedef enum logic [0:0] {
		CFG_WEAK_AMP_THR = 1'b0,
		CFG_SYNC_ERR_THR = 1'b1
	} cfg_idx_t;

endpackage

### rtl/dqse_ram.sv
module dqse_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/dqpsk_symbol_extract_sync.sv
// Channel   Handshake            Payload
// input     in_valid / in_ready  sample_re, sample_im, block_end
// output    out_valid/out_ready  dibit, sync_locked, mean_error, metric_updated,
//                                block_end_res
// config    cfg_we               cfg_index, cfg_data
//
// One item per cycle is sustained while out_ready stays high; a result passes the window
// RAM read, the running-sum update and the publish stage ahead of the output register.
// Each stage holds its item on its own, so input is still taken while a
// result waits, as long as a stage ahead is empty or moving.
// After reset the window reads as zero through a fill flag; there is no
// clearing pass and items are accepted at once.
module dqpsk_symbol_extract_sync (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [dqse_pkg::SAMPLE_W-1:0]  sample_re,
	input  logic signed [dqse_pkg::SAMPLE_W-1:0]  sample_im,
	input  logic                                  block_end,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [dqse_pkg::DIBIT_W-1:0]          dibit,
	output logic                                  sync_locked,
	output logic [dqse_pkg::MEAN_W-1:0]           mean_error,
	output logic                                  metric_updated,
	output logic                                  block_end_res,
	input  logic                                  cfg_we,
	input  dqse_pkg::cfg_idx_t                    cfg_index,
	input  logic [dqse_pkg::CFG_W-1:0]            cfg_data
);

	import dqse_pkg::*;

	// Configuration.
	logic [WEAK_W-1:0] weak_thr_q;
	logic [SYNC_W-1:0] sync_thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weak_thr_q <= WEAK_THR_RESET;
			sync_thr_q <= SYNC_THR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WEAK_AMP_THR: weak_thr_q <= cfg_data[WEAK_W-1:0];
				CFG_SYNC_ERR_THR: sync_thr_q <= cfg_data[SYNC_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage handshake.
	logic v_s1, v_s2, v_s3, out_v_q;
	logic adv_s1, adv_s2, adv_s3, accept;

	assign adv_s3   = v_s3 && (!out_v_q || out_ready);
	assign adv_s2   = v_s2 && (!v_s3 || adv_s3);
	assign adv_s1   = v_s1 && (!v_s2 || adv_s2);
	assign in_ready = !v_s1 || adv_s1;
	assign accept   = in_valid && in_ready;

	// Input stage: magnitudes, quadrant decision and differential decode.
	logic             neg_re, neg_im;
	logic [ABS_W-1:0] abs_re, abs_im, mx, mn;
	logic [1:0]       sym, diff;
	logic [1:0]       prev_sym_q;
	logic [WIN_AW-1:0] widx_q;
	logic              filled_q;

	always_comb begin
		neg_re = sample_re[SAMPLE_W-1];
		neg_im = sample_im[SAMPLE_W-1];
		abs_re = neg_re ? (~sample_re + 1'b1) : sample_re;
		abs_im = neg_im ? (~sample_im + 1'b1) : sample_im;
		mx     = (abs_re > abs_im) ? abs_re : abs_im;
		mn     = (abs_re > abs_im) ? abs_im : abs_re;
		sym    = {neg_im, neg_im ^ neg_re};
		diff   = sym - prev_sym_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_sym_q <= '0;
			widx_q     <= '0;
			filled_q   <= 1'b0;
		end else if (accept) begin
			prev_sym_q <= sym;
			if (widx_q == WIN_AW'(WINDOW_LENGTH - 1)) begin
				widx_q   <= '0;
				filled_q <= 1'b1;
			end else begin
				widx_q <= widx_q + 1'b1;
			end
		end
	end

	// Stage 1 holds the sample; the window entry is read as it moves on.
	logic [ABS_W-1:0]   mx_s1, mn_s1;
	logic [DIBIT_W-1:0] dibit_s1;
	logic               blk_s1, old_ok_s1;
	logic [WIN_AW-1:0]  idx_s1;
	logic [PROD_W-1:0]  prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mx_s1     <= mx;
			mn_s1     <= mn;
			dibit_s1  <= {diff[1], diff[1] ^ diff[0]};
			blk_s1    <= block_end;
			old_ok_s1 <= filled_q;
			idx_s1    <= widx_q;
		end
	end

	assign prod = {mn_s1, 1'b0} * DIV5_MUL_W'(DIV5_MUL);

	// Stage 2: amplitude test, window write and running-sum update.
	logic [ABS_W-1:0]   mx_s2, dist_s2;
	logic [QUOT_W-1:0]  quot_s2;
	logic [DIBIT_W-1:0] dibit_s2;
	logic               blk_s2, old_ok_s2;
	logic [WIN_AW-1:0]  idx_s2;
	logic [ABS_W-1:0]   ram_rdata, old_err, err;
	logic [AMP_W-1:0]   amp;
	logic [SUM_W-1:0]   sum_q, sum_next;
	logic [CNT_W-1:0]   cnt_q;
	logic               pub_now;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (!v_s2 || adv_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			mx_s2     <= mx_s1;
			dist_s2   <= mx_s1 - mn_s1;
			quot_s2   <= prod[DIV5_SH +: QUOT_W];
			dibit_s2  <= dibit_s1;
			blk_s2    <= blk_s1;
			old_ok_s2 <= old_ok_s1;
			idx_s2    <= idx_s1;
		end
	end

	// The item in stage 1 always reads the entry after the one stage 2
	// writes, and an entry is read again only a full window later, so the
	// read-modify-write needs no forwarding.
	dqse_ram #(
		.WIDTH (ABS_W),
		.DEPTH (WINDOW_LENGTH)
	) u_window (
		.clk   (clk),
		.we    (adv_s2),
		.waddr (idx_s2),
		.wdata (err),
		.re    (adv_s1),
		.raddr (idx_s1),
		.rdata (ram_rdata)
	);

	always_comb begin
		amp      = AMP_W'(mx_s2) + AMP_W'(quot_s2);
		err      = (amp < AMP_W'(weak_thr_q)) ? '0 : dist_s2;
		// Entries not yet written since reset count as zero.
		old_err  = old_ok_s2 ? ram_rdata : '0;
		sum_next = sum_q - SUM_W'(old_err) + SUM_W'(err);
		pub_now  = (cnt_q == CNT_W'(UPDATE_INTERVAL - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (adv_s2) begin
			sum_q <= sum_next;
			cnt_q <= pub_now ? '0 : cnt_q + 1'b1;
		end
	end

	// Stage 3: publish the mean and decide sync. sum_q already holds this
	// item's update and no later one while the item sits here.
	logic [DIBIT_W-1:0] dibit_s3;
	logic               blk_s3, pub_s3;
	logic [ABS_W-1:0]   mean;
	logic               lock_new;
	logic [ABS_W-1:0]   pub_mean_q;
	logic               sync_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (!v_s3 || adv_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			dibit_s3 <= dibit_s2;
			blk_s3   <= blk_s2;
			pub_s3   <= pub_now;
		end
	end

	assign mean     = sum_q[SUM_W-1:WIN_AW];
	assign lock_new = (SYNC_W'(mean) < sync_thr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pub_mean_q <= '0;
			sync_q     <= 1'b0;
		end else if (adv_s3 && pub_s3) begin
			pub_mean_q <= mean;
			sync_q     <= lock_new;
		end
	end

	// Output register.
	logic [DIBIT_W-1:0] dibit_q;
	logic               sync_out_q, upd_q, blk_q;
	logic [ABS_W-1:0]   mean_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (!out_v_q || out_ready) begin
			out_v_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			dibit_q    <= dibit_s3;
			blk_q      <= blk_s3;
			upd_q      <= pub_s3;
			sync_out_q <= pub_s3 ? lock_new : sync_q;
			mean_out_q <= pub_s3 ? mean : pub_mean_q;
		end
	end

	assign out_valid      = out_v_q;
	assign dibit          = dibit_q;
	assign sync_locked    = sync_out_q;
	assign mean_error     = MEAN_W'(mean_out_q);
	assign metric_updated = upd_q;
	assign block_end_res  = blk_q;

	// Checks.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(UPDATE_INTERVAL - 1))
		else $error("update counter out of range");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> v_s1)
		else $error("accepted item lost before stage 1");

	a_pub_carried: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s2 && pub_now |=> v_s3 && pub_s3)
		else $error("publish mark not carried into stage 3");

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && adv_s2 |-> idx_s1 != idx_s2)
		else $error("window read and write hit the same entry");

endmodule
